[rtl/udp_rx_checksum_port_demux_top_macros.svh]
// ----------------------------------------------------------------------------
// udp receive checksum / port demux: assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef UDP_RX_CHECKSUM_PORT_DEMUX_TOP_MACROS_SVH
`define UDP_RX_CHECKSUM_PORT_DEMUX_TOP_MACROS_SVH

// property must hold at every edge out of reset
`define UDPRX_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true out of reset
`define UDPRX_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

[rtl/udprx_pkg.sv]
// ----------------------------------------------------------------------------
// udprx_pkg
// shared constants, codes, item structs and one's-complement fold
// ----------------------------------------------------------------------------
`default_nettype none

package udprx_pkg;

	// port table
	localparam int PORT_SLOTS = 8;
	localparam int SLOT_W     = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
	typedef logic [SLOT_W-1:0] slot_idx_t;

	// queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// stream widths
	localparam int S_DATA_W = 88;
	localparam int S_USER_W = 3;
	localparam int M_DATA_W = 40;
	localparam int M_USER_W = 2;

	// opcodes
	localparam logic [1:0] OP_BYTE   = 2'd0;
	localparam logic [1:0] OP_BIND   = 2'd1;
	localparam logic [1:0] OP_UNBIND = 2'd2;

	// reply kinds
	localparam logic [1:0] KIND_BIND    = 2'd0;
	localparam logic [1:0] KIND_UNBIND  = 2'd1;
	localparam logic [1:0] KIND_VERDICT = 2'd2;

	// datagram verdicts
	localparam logic [2:0] ST_DELIVER     = 3'd0;
	localparam logic [2:0] ST_SHORT       = 3'd1;
	localparam logic [2:0] ST_BAD_LEN     = 3'd2;
	localparam logic [2:0] ST_BAD_CSUM    = 3'd3;
	localparam logic [2:0] ST_NO_LISTENER = 3'd4;
	// bind replies
	localparam logic [2:0] ST_BIND_OK     = 3'd0;
	localparam logic [2:0] ST_BIND_DUP    = 3'd1;
	localparam logic [2:0] ST_BIND_FULL   = 3'd2;
	// unbind replies
	localparam logic [2:0] ST_UNBIND_OK     = 3'd0;
	localparam logic [2:0] ST_UNBIND_ABSENT = 3'd1;

	localparam logic [15:0] HDR_LEN   = 16'd8;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam logic [15:0] SUM_OK    = 16'hFFFF;
	localparam logic [18:0] UDP_PROTO = 19'd17;

	// classified item, front to back
	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] port;
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [15:0] addr_sum;
	} item_t;

	// item handed from the accumulator to the table/verdict stage
	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] port;
		logic [15:0] count;
		logic [15:0] sum;
		logic [7:0]  pending;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [15:0] len;
		logic [15:0] csum;
		logic [15:0] addr_sum;
	} snap_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  status;
		logic [2:0]  slot;
		logic [15:0] sport;
		logic [15:0] plen;
	} result_t;

	// end-around carry fold of a sum of up to eight 16-bit words
	function automatic logic [15:0] oc_fold(input logic [18:0] s);
		logic [16:0] t;
		t = {1'b0, s[15:0]} + {14'd0, s[18:16]};
		return t[15:0] + {15'd0, t[16]};
	endfunction

endpackage

`default_nettype wire

[rtl/udprx_front.sv]
// ----------------------------------------------------------------------------
// udprx_front
// input register: unpacks, drops unknown opcodes, pre-sums the address words
// ----------------------------------------------------------------------------
`default_nettype none

module udprx_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [udprx_pkg::S_DATA_W-1:0] in_data,
	input  wire logic [udprx_pkg::S_USER_W-1:0] in_user,
	input  wire logic                           in_last,
	output logic                                q_valid,
	input  wire logic                           q_ready,
	output udprx_pkg::item_t                    q_item
);

	logic              valid_s1;
	udprx_pkg::item_t  item_s1;
	udprx_pkg::item_t  item_c;
	logic              known;
	logic [18:0]       addr_wide;

	assign known = (in_user[1:0] == udprx_pkg::OP_BYTE) ||
	               (in_user[1:0] == udprx_pkg::OP_BIND) ||
	               (in_user[1:0] == udprx_pkg::OP_UNBIND);

	// pseudo-header addresses plus protocol, folded early
	assign addr_wide = {3'd0, in_data[55:40]} + {3'd0, in_data[39:24]} +
	                   {3'd0, in_data[87:72]} + {3'd0, in_data[71:56]} +
	                   udprx_pkg::UDP_PROTO;

	always_comb begin
		item_c.op       = in_user[1:0];
		item_c.port     = in_data[15:0];
		item_c.data     = in_data[23:16];
		item_c.first    = in_user[2];
		item_c.last     = in_last;
		item_c.addr_sum = udprx_pkg::oc_fold(addr_wide);
	end

	assign in_ready = !valid_s1 || q_ready;
	assign q_valid  = valid_s1;
	assign q_item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && known;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_c;
		end
	end

endmodule

`default_nettype wire

[rtl/udprx_fifo.sv]
// ----------------------------------------------------------------------------
// udprx_fifo
// short register queue decoupling the front from the back
// ----------------------------------------------------------------------------
`default_nettype none
`include "udp_rx_checksum_port_demux_top_macros.svh"

module udprx_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire udprx_pkg::item_t in_item,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output udprx_pkg::item_t      out_item
);

	udprx_pkg::item_t                  mem_q [udprx_pkg::FIFO_DEPTH];
	logic [udprx_pkg::FIFO_AW-1:0]     wr_ptr_q;
	logic [udprx_pkg::FIFO_AW-1:0]     rd_ptr_q;
	logic [udprx_pkg::FIFO_CW-1:0]     count_q;
	logic                              push;
	logic                              pop;

	assign in_ready  = (count_q != udprx_pkg::FIFO_CW'(udprx_pkg::FIFO_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_item  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == udprx_pkg::FIFO_AW'(udprx_pkg::FIFO_DEPTH - 1)) ?
				            '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == udprx_pkg::FIFO_AW'(udprx_pkg::FIFO_DEPTH - 1)) ?
				            '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	`UDPRX_ASSERT_NEVER(a_fifo_overfill, count_q > udprx_pkg::FIFO_CW'(udprx_pkg::FIFO_DEPTH), "queue occupancy above depth")

endmodule

`default_nettype wire

[rtl/udprx_back.sv]
// ----------------------------------------------------------------------------
// udprx_back
// datagram accumulator, port table and verdict stage with output register
// ----------------------------------------------------------------------------
`default_nettype none
`include "udp_rx_checksum_port_demux_top_macros.svh"

module udprx_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             f_valid,
	output logic                  f_ready,
	input  wire udprx_pkg::item_t f_item,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output udprx_pkg::result_t    res
);

	// datagram state
	logic [15:0] cnt_q, sum_q, sport_q, dport_q, len_q, csum_q;
	logic [7:0]  pend_q;

	// table state
	logic [udprx_pkg::PORT_SLOTS-1:0] slot_valid_q;
	logic [15:0]                      slot_port_q [udprx_pkg::PORT_SLOTS];

	// stage registers
	logic                 valid_s2;
	udprx_pkg::snap_t     snap_s2;
	logic                 out_valid_q;
	udprx_pkg::result_t   out_q;

	// accumulator next values
	logic [15:0] pos, b_sum, b_sport, b_dport, b_len, b_csum;
	logic [7:0]  b_pend;
	logic [15:0] n_cnt, n_sum, n_sport, n_dport, n_len, n_csum;
	logic [7:0]  n_pend;
	logic        take;
	logic        need_s2, pop, s2_ready, out_ready, fire_b;
	udprx_pkg::snap_t snap_c;

	// table lookup and verdict
	logic [15:0]                      key;
	logic                             hit_any, free_any;
	udprx_pkg::slot_idx_t             hit_idx, free_idx;
	logic [18:0]                      chk_wide;
	logic [15:0]                      chk, pad;
	udprx_pkg::result_t               res_c;

	assign out_ready = !out_valid_q || res_ready;
	assign s2_ready  = !valid_s2 || out_ready;
	assign fire_b    = valid_s2 && out_ready;
	assign need_s2   = (f_item.op != udprx_pkg::OP_BYTE) || f_item.last;
	assign f_ready   = !need_s2 || s2_ready;
	assign pop       = f_valid && f_ready;

	always_comb begin
		pos     = f_item.first ? '0 : cnt_q;
		b_sum   = f_item.first ? '0 : sum_q;
		b_pend  = f_item.first ? '0 : pend_q;
		b_sport = f_item.first ? '0 : sport_q;
		b_dport = f_item.first ? '0 : dport_q;
		b_len   = f_item.first ? '0 : len_q;
		b_csum  = f_item.first ? '0 : csum_q;

		n_sport = b_sport;
		n_dport = b_dport;
		n_len   = b_len;
		n_csum  = b_csum;
		case (pos)
			16'd0:   n_sport = {f_item.data, b_sport[7:0]};
			16'd1:   n_sport = {b_sport[15:8], f_item.data};
			16'd2:   n_dport = {f_item.data, b_dport[7:0]};
			16'd3:   n_dport = {b_dport[15:8], f_item.data};
			16'd4:   n_len   = {f_item.data, b_len[7:0]};
			16'd5:   n_len   = {b_len[15:8], f_item.data};
			16'd6:   n_csum  = {f_item.data, b_csum[7:0]};
			16'd7:   n_csum  = {b_csum[15:8], f_item.data};
			default: ;
		endcase

		// header always summed, payload only inside the length field
		take   = (pos != udprx_pkg::COUNT_MAX) && ((pos < udprx_pkg::HDR_LEN) || (pos < b_len));
		n_pend = (take && !pos[0]) ? f_item.data : b_pend;
		n_sum  = (take && pos[0]) ?
		         udprx_pkg::oc_fold({3'd0, b_sum} + {3'd0, b_pend, f_item.data}) : b_sum;
		n_cnt  = (pos == udprx_pkg::COUNT_MAX) ? pos : pos + 16'd1;

		snap_c.op       = f_item.op;
		snap_c.port     = f_item.port;
		snap_c.count    = n_cnt;
		snap_c.sum      = n_sum;
		snap_c.pending  = n_pend;
		snap_c.sport    = n_sport;
		snap_c.dport    = n_dport;
		snap_c.len      = n_len;
		snap_c.csum     = n_csum;
		snap_c.addr_sum = f_item.addr_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			pend_q  <= '0;
			sport_q <= '0;
			dport_q <= '0;
			len_q   <= '0;
			csum_q  <= '0;
		end else if (pop && (f_item.op == udprx_pkg::OP_BYTE)) begin
			if (f_item.last) begin
				cnt_q   <= '0;
				sum_q   <= '0;
				pend_q  <= '0;
				sport_q <= '0;
				dport_q <= '0;
				len_q   <= '0;
				csum_q  <= '0;
			end else begin
				cnt_q   <= n_cnt;
				sum_q   <= n_sum;
				pend_q  <= n_pend;
				sport_q <= n_sport;
				dport_q <= n_dport;
				len_q   <= n_len;
				csum_q  <= n_csum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (pop && need_s2) begin
			valid_s2 <= 1'b1;
		end else if (fire_b) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && need_s2) begin
			snap_s2 <= snap_c;
		end
	end

	// parallel slot compare, lowest slot wins
	assign key = (snap_s2.op == udprx_pkg::OP_BYTE) ? snap_s2.dport : snap_s2.port;

	always_comb begin
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = udprx_pkg::PORT_SLOTS - 1; i >= 0; i--) begin
			if (slot_valid_q[i] && (slot_port_q[i] == key)) begin
				hit_any = 1'b1;
				hit_idx = udprx_pkg::slot_idx_t'(i);
			end
			if (!slot_valid_q[i]) begin
				free_any = 1'b1;
				free_idx = udprx_pkg::slot_idx_t'(i);
			end
		end
	end

	assign pad      = snap_s2.len[0] ? {snap_s2.pending, 8'h00} : 16'h0000;
	assign chk_wide = {3'd0, snap_s2.sum} + {3'd0, pad} + {3'd0, snap_s2.addr_sum} +
	                  {3'd0, snap_s2.len};
	assign chk      = udprx_pkg::oc_fold(chk_wide);

	always_comb begin
		res_c = '0;
		case (snap_s2.op)
			udprx_pkg::OP_BIND: begin
				res_c.kind = udprx_pkg::KIND_BIND;
				if (hit_any) begin
					res_c.status = udprx_pkg::ST_BIND_DUP;
					res_c.slot   = 3'(hit_idx);
				end else if (free_any) begin
					res_c.status = udprx_pkg::ST_BIND_OK;
					res_c.slot   = 3'(free_idx);
				end else begin
					res_c.status = udprx_pkg::ST_BIND_FULL;
				end
			end
			udprx_pkg::OP_UNBIND: begin
				res_c.kind = udprx_pkg::KIND_UNBIND;
				if (hit_any) begin
					res_c.status = udprx_pkg::ST_UNBIND_OK;
					res_c.slot   = 3'(hit_idx);
				end else begin
					res_c.status = udprx_pkg::ST_UNBIND_ABSENT;
				end
			end
			default: begin
				res_c.kind = udprx_pkg::KIND_VERDICT;
				if (snap_s2.count < udprx_pkg::HDR_LEN) begin
					res_c.status = udprx_pkg::ST_SHORT;
				end else begin
					res_c.sport = snap_s2.sport;
					if ((snap_s2.len < udprx_pkg::HDR_LEN) || (snap_s2.len > snap_s2.count)) begin
						res_c.status = udprx_pkg::ST_BAD_LEN;
					end else if ((snap_s2.csum != 16'd0) && (chk != udprx_pkg::SUM_OK)) begin
						res_c.status = udprx_pkg::ST_BAD_CSUM;
					end else if (hit_any) begin
						res_c.status = udprx_pkg::ST_DELIVER;
						res_c.slot   = 3'(hit_idx);
						res_c.plen   = snap_s2.len - udprx_pkg::HDR_LEN;
					end else begin
						res_c.status = udprx_pkg::ST_NO_LISTENER;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (fire_b) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire_b && (snap_s2.op == udprx_pkg::OP_BIND) && !hit_any && free_any) begin
				slot_valid_q[free_idx] <= 1'b1;
			end
			if (fire_b && (snap_s2.op == udprx_pkg::OP_UNBIND) && hit_any) begin
				slot_valid_q[hit_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_b) begin
			out_q <= res_c;
		end
		if (fire_b && (snap_s2.op == udprx_pkg::OP_BIND) && !hit_any && free_any) begin
			slot_port_q[free_idx] <= snap_s2.port;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	`UDPRX_ASSERT(a_bind_sets_slot, (fire_b && (snap_s2.op == udprx_pkg::OP_BIND) && !hit_any && free_any) |=> slot_valid_q[$past(free_idx)], "bound slot not marked valid")
	`UDPRX_ASSERT(a_unbind_clears_slot, (fire_b && (snap_s2.op == udprx_pkg::OP_UNBIND) && hit_any) |=> !slot_valid_q[$past(hit_idx)], "unbound slot still valid")
	`UDPRX_ASSERT(a_last_clears_count, (pop && (f_item.op == udprx_pkg::OP_BYTE) && f_item.last) |=> (cnt_q == 16'd0), "datagram state kept after verdict")

endmodule

`default_nettype wire

[rtl/udp_rx_checksum_port_demux_top.sv]
// ----------------------------------------------------------------------------
// udp_rx_checksum_port_demux_top
// udp receive checksum check and port demultiplexer, stream in / stream out
// ----------------------------------------------------------------------------
// usage
//   s_* carries one transfer per datagram byte, bind request or unbind request.
//   tuser gives the opcode and the first-byte mark, tlast marks the last byte.
//   bytes without tlast are absorbed; a last byte, a bind and an unbind each
//   give one reply transfer on m_*, in order. opcode 3 is taken and discarded.
//   throughput: one transfer per cycle on both sides while m_tready is high, set
//   by the byte accumulator and eight parallel port compares in the back stage.
//   path: a reply passes the front register, the queue, the accumulator stage
//   and the verdict register, in that order, before it leaves on m_*.
//   reset: port table empty, datagram sum, count and header cleared, queues
//   empty; s_tready is already high while reset is held, and transfers are
//   taken from the first clock edge after release.
//   stall: the output register holds its reply while m_tready is low; the
//   verdict stage, the 4-entry queue and the front register fill behind it,
//   then s_tready drops. plain bytes keep draining until a reply-bearing item
//   reaches the head of the queue.
//   the address pre-sum is folded in the front register, the datagram sum
//   per byte in the accumulator, and the pseudo-header completed at verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module udp_rx_checksum_port_demux_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input stream
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// port_number[15:0], data_byte[23:16], source_address[55:24],
	// destination_address[87:56]
	input  wire logic [udprx_pkg::S_DATA_W-1:0] s_tdata,
	// opcode[1:0], first_byte[2]
	input  wire logic [udprx_pkg::S_USER_W-1:0] s_tuser,
	// last_byte
	input  wire logic                           s_tlast,
	// reply stream
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// status[2:0], slot[5:3], sender_port[21:6], payload_length[37:22], zero pad
	output logic [udprx_pkg::M_DATA_W-1:0]      m_tdata,
	// reply_kind[1:0]
	output logic [udprx_pkg::M_USER_W-1:0]      m_tuser
);

	// front register to queue
	logic               fq_valid, fq_ready;
	udprx_pkg::item_t   fq_item;
	// queue to back
	logic               qb_valid, qb_ready;
	udprx_pkg::item_t   qb_item;
	// back to reply port
	udprx_pkg::result_t reply;

	// classify and pre-sum the pseudo-header addresses
	udprx_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (s_tdata),
		.in_user  (s_tuser),
		.in_last  (s_tlast),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_item   (fq_item)
	);

	// decoupling queue
	udprx_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_item   (fq_item),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_item  (qb_item)
	);

	// accumulate, look up ports, give verdicts
	udprx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.f_valid   (qb_valid),
		.f_ready   (qb_ready),
		.f_item    (qb_item),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (reply)
	);

	// reply packing, lowest field first
	assign m_tdata = {2'b00, reply.plen, reply.sport, reply.slot, reply.status};
	assign m_tuser = reply.kind;

endmodule

`default_nettype wire
